/* sv/cgd_pkg.sv */
package cgd_pkg;

  localparam int ScoreW     = 16;
  localparam int ClassW     = 13;
  localparam int MaxClasses = 8192;
  localparam int PosW       = $clog2(MaxClasses) + 1;
  localparam int DictW      = 14;
  localparam int SumW       = 25;
  localparam int CountW     = 10;
  localparam int QDepth     = 4;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int DivSteps   = ScoreW;
  localparam int DivStepW   = $clog2(DivSteps);
  localparam int RemW       = CountW + 1;
  localparam int DictReset  = 8192;
  localparam int AddrW      = 3;
  localparam int DataW      = 32;

  // register byte addresses, word index in paddr[2]
  localparam logic [AddrW-1:0] RegDictSize = 3'd0;

  typedef struct packed {
    logic              emit;
    logic [ClassW-1:0] winner;
    logic [ScoreW-1:0] score;
    logic              seq_end;
  } event_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

endpackage

/* sv/cgd_front.sv */
module cgd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [cgd_pkg::ScoreW-1:0] class_score,
  input  logic                      step_end,
  input  logic                      sequence_end,
  input  logic [cgd_pkg::DictW-1:0] dict_size,
  input  logic                      q_full,
  output logic                      q_push,
  output cgd_pkg::event_t           q_data
);

  logic [cgd_pkg::PosW-1:0]   pos_r, pos_nxt;
  logic [cgd_pkg::ScoreW-1:0] best_score_r, best_score_nxt;
  logic [cgd_pkg::ClassW-1:0] best_class_r, best_class_nxt;
  logic [cgd_pkg::ClassW-1:0] prev_r, prev_nxt;

  logic                       fire;
  logic                       take;
  logic                       better;
  logic                       step_done;
  logic                       emit;
  logic [cgd_pkg::ScoreW-1:0] cur_score;
  logic [cgd_pkg::ClassW-1:0] cur_class;

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    // classes past the saturation point are ignored
    take      = pos_r < cgd_pkg::PosW'(cgd_pkg::MaxClasses);
    better    = take && ((pos_r == '0) || (class_score > best_score_r));
    cur_score = better ? class_score : best_score_r;
    cur_class = better ? pos_r[cgd_pkg::ClassW-1:0] : best_class_r;
    step_done = step_end || sequence_end;
    emit      = step_done && (cur_class != '0) && (cur_class != prev_r)
                && (cgd_pkg::DictW'(cur_class) < dict_size);

    q_push         = fire && (emit || sequence_end);
    q_data.emit    = emit;
    q_data.winner  = cur_class;
    q_data.score   = cur_score;
    q_data.seq_end = sequence_end;

    pos_nxt        = pos_r;
    best_score_nxt = best_score_r;
    best_class_nxt = best_class_r;
    prev_nxt       = prev_r;
    if (fire) begin
      if (step_done) begin
        pos_nxt        = '0;
        best_score_nxt = '0;
        best_class_nxt = '0;
        prev_nxt       = sequence_end ? '0 : cur_class;
      end else begin
        pos_nxt        = take ? pos_r + 1'b1 : pos_r;
        best_score_nxt = cur_score;
        best_class_nxt = cur_class;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      best_score_r <= '0;
      best_class_r <= '0;
      prev_r       <= '0;
    end else begin
      pos_r        <= pos_nxt;
      best_score_r <= best_score_nxt;
      best_class_r <= best_class_nxt;
      prev_r       <= prev_nxt;
    end
  end

endmodule

/* sv/cgd_queue.sv */
module cgd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cgd_pkg::event_t push_data,
  output logic            full,
  output logic            valid,
  output cgd_pkg::event_t data,
  input  logic            pop
);

  cgd_pkg::event_t             mem_r [cgd_pkg::QDepth];
  logic [cgd_pkg::QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [cgd_pkg::QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [cgd_pkg::QPtrW:0]     count_r, count_nxt;

  assign full  = count_r == (cgd_pkg::QPtrW+1)'(cgd_pkg::QDepth);
  assign valid = count_r != '0;
  assign data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (cgd_pkg::QPtrW+1)'(push) - (cgd_pkg::QPtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/cgd_back.sv */
module cgd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  cgd_pkg::event_t            q_data,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic                       char_valid,
  output logic [cgd_pkg::ClassW-1:0] char_index,
  output logic                       done_res,
  output logic [cgd_pkg::ScoreW-1:0] avg_confidence
);

  cgd_pkg::back_state_t state_r, state_nxt;

  logic [cgd_pkg::SumW-1:0]     sum_r, sum_nxt;
  logic [cgd_pkg::CountW-1:0]   cnt_r, cnt_nxt;
  logic [cgd_pkg::DivStepW-1:0] step_r, step_nxt;
  logic [cgd_pkg::RemW-1:0]     rem_r, rem_nxt;
  logic [cgd_pkg::ScoreW-1:0]   quo_r, quo_nxt;
  logic [cgd_pkg::ScoreW-1:0]   divd_r, divd_nxt;
  logic [cgd_pkg::CountW-1:0]   dvsr_r, dvsr_nxt;
  logic                         hold_emit_r, hold_emit_nxt;
  logic [cgd_pkg::ClassW-1:0]   hold_winner_r, hold_winner_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         char_valid_r, char_valid_nxt;
  logic [cgd_pkg::ClassW-1:0]   char_index_r, char_index_nxt;
  logic                         done_r, done_nxt;
  logic [cgd_pkg::ScoreW-1:0]   avg_r, avg_nxt;

  logic                         slot_free;
  logic [cgd_pkg::SumW:0]       sum_try;
  logic                         acc;
  logic [cgd_pkg::SumW-1:0]     new_sum;
  logic [cgd_pkg::CountW-1:0]   new_cnt;
  logic [cgd_pkg::RemW-1:0]     trial;
  logic                         qbit;

  assign out_tvalid     = out_valid_r;
  assign char_valid     = char_valid_r;
  assign char_index     = char_index_r;
  assign done_res       = done_r;
  assign avg_confidence = avg_r;

  always_comb begin
    slot_free = !out_valid_r || out_tready;
    // accumulate only while neither count nor sum would overflow
    sum_try   = {1'b0, sum_r} + (cgd_pkg::SumW+1)'(q_data.score);
    acc       = q_data.emit && (cnt_r != '1) && !sum_try[cgd_pkg::SumW];
    new_sum   = acc ? sum_try[cgd_pkg::SumW-1:0] : sum_r;
    new_cnt   = acc ? cnt_r + 1'b1 : cnt_r;
    // one restoring quotient bit per cycle
    trial     = {rem_r[cgd_pkg::RemW-2:0], divd_r[cgd_pkg::ScoreW-1]};
    qbit      = trial >= cgd_pkg::RemW'(dvsr_r);

    state_nxt       = state_r;
    sum_nxt         = sum_r;
    cnt_nxt         = cnt_r;
    step_nxt        = step_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    divd_nxt        = divd_r;
    dvsr_nxt        = dvsr_r;
    hold_emit_nxt   = hold_emit_r;
    hold_winner_nxt = hold_winner_r;
    out_valid_nxt   = out_tready ? 1'b0 : out_valid_r;
    char_valid_nxt  = char_valid_r;
    char_index_nxt  = char_index_r;
    done_nxt        = done_r;
    avg_nxt         = avg_r;
    q_pop           = 1'b0;

    unique case (state_r)
      cgd_pkg::BK_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          if (q_data.seq_end) begin
            rem_nxt         = cgd_pkg::RemW'(new_sum[cgd_pkg::SumW-1:cgd_pkg::ScoreW]);
            divd_nxt        = new_sum[cgd_pkg::ScoreW-1:0];
            dvsr_nxt        = new_cnt;
            quo_nxt         = '0;
            step_nxt        = '0;
            hold_emit_nxt   = q_data.emit;
            hold_winner_nxt = q_data.winner;
            sum_nxt         = '0;
            cnt_nxt         = '0;
            state_nxt       = cgd_pkg::BK_DIV;
          end else begin
            sum_nxt        = new_sum;
            cnt_nxt        = new_cnt;
            out_valid_nxt  = 1'b1;
            char_valid_nxt = 1'b1;
            char_index_nxt = q_data.winner;
            done_nxt       = 1'b0;
            avg_nxt        = '0;
          end
        end
      end
      cgd_pkg::BK_DIV: begin
        rem_nxt  = qbit ? trial - cgd_pkg::RemW'(dvsr_r) : trial;
        quo_nxt  = {quo_r[cgd_pkg::ScoreW-2:0], qbit};
        divd_nxt = {divd_r[cgd_pkg::ScoreW-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == cgd_pkg::DivStepW'(cgd_pkg::DivSteps - 1)) begin
          state_nxt = cgd_pkg::BK_FIN;
        end
      end
      cgd_pkg::BK_FIN: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          char_valid_nxt = hold_emit_r;
          char_index_nxt = hold_emit_r ? hold_winner_r : '0;
          done_nxt       = 1'b1;
          avg_nxt        = (dvsr_r == '0) ? '0 : quo_r;
          state_nxt      = cgd_pkg::BK_IDLE;
        end
      end
      default: state_nxt = cgd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cgd_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r        <= step_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    divd_r        <= divd_nxt;
    dvsr_r        <= dvsr_nxt;
    hold_emit_r   <= hold_emit_nxt;
    hold_winner_r <= hold_winner_nxt;
    char_valid_r  <= char_valid_nxt;
    char_index_r  <= char_index_nxt;
    done_r        <= done_nxt;
    avg_r         <= avg_nxt;
  end

endmodule

/* sv/ctc_greedy_decoder.sv */
// ctc greedy best-path decoder
// in_*: one class score per transaction, classes of a time step in order;
//   in_tuser marks the last class of a step, in_tlast the last class of the
//   sequence (it also closes the step). a running argmax per step picks the
//   winner, ties to the lower class index.
// out_*: a transaction when a step's winner is emitted as a character (not
//   blank, not a repeat of the previous winner, below dict_size); the last
//   step's rides on the closing transaction per sequence, with floor mean confidence.
// cfg_*: apb register dict_size at byte address 0, write only while idle.
// throughput: one input transaction per cycle while in_tready is high. a
//   character result passes through the event queue and the output register.
//   the sequence result runs a restoring divider (one quotient bit per cycle)
//   before it leaves; meanwhile the 4-entry event queue keeps taking results
//   and in_tready drops only when that queue is full.
// a stalled receiver holds the output register; the queue then fills and
//   backs up into in_tready.
// reset (synchronous, active low) clears the argmax, previous winner,
//   confidence sum and count, empties the queue and sets dict_size to 8192.
module ctc_greedy_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // class_score
  input  logic                           in_tuser,   // step_end
  input  logic                           in_tlast,   // sequence_end
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // char_index, avg_confidence, zero pad
  output logic                           out_tuser,  // char_valid
  output logic                           out_tlast,  // done_res
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cgd_pkg::AddrW-1:0]      cfg_paddr,
  input  logic [cgd_pkg::DataW-1:0]      cfg_pwdata,
  output logic [cgd_pkg::DataW-1:0]      cfg_prdata,
  output logic                           cfg_pready
);

  logic [cgd_pkg::DictW-1:0]  dict_size_r, dict_size_nxt;
  logic                       cfg_wr;
  logic                       q_push;
  logic                       q_full;
  logic                       q_valid;
  logic                       q_pop;
  cgd_pkg::event_t            push_data;
  cgd_pkg::event_t            pop_data;
  logic [cgd_pkg::ClassW-1:0] char_index;
  logic [cgd_pkg::ScoreW-1:0] avg_confidence;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    dict_size_nxt = dict_size_r;
    if (cfg_wr && (cfg_paddr[cgd_pkg::AddrW-1] == cgd_pkg::RegDictSize[cgd_pkg::AddrW-1])) begin
      dict_size_nxt = cfg_pwdata[cgd_pkg::DictW-1:0];
    end
    cfg_prdata = '0;
    if (cfg_paddr[cgd_pkg::AddrW-1] == cgd_pkg::RegDictSize[cgd_pkg::AddrW-1]) begin
      cfg_prdata = cgd_pkg::DataW'(dict_size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_size_r <= cgd_pkg::DictW'(cgd_pkg::DictReset);
    end else begin
      dict_size_r <= dict_size_nxt;
    end
  end

  cgd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .class_score  (in_tdata),
    .step_end     (in_tuser),
    .sequence_end (in_tlast),
    .dict_size    (dict_size_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  cgd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .valid     (q_valid),
    .data      (pop_data),
    .pop       (q_pop)
  );

  cgd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (pop_data),
    .q_pop          (q_pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .char_valid     (out_tuser),
    .char_index     (char_index),
    .done_res       (out_tlast),
    .avg_confidence (avg_confidence)
  );

  assign out_tdata = {3'b000, avg_confidence, char_index};

  // the event queue is never written while full
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("event queue overflow");

  // the back end only pops an entry that is present
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("event queue underflow");

  // a result that does not close the sequence always carries a character and no mean
  assert property (@(posedge clk) disable iff (!rst_n)
      (out_tvalid && !out_tlast) |-> (out_tuser && (avg_confidence == '0)))
    else $error("non-closing result without a character");

endmodule
